// ===== rtl/core/rpd_pkg.sv =====
`default_nettype none

package rpd_pkg;

  // Channel count and field widths
  localparam int NUM_CHANNELS = 4;
  localparam int TIME_W       = 32;
  localparam int WIDTH_W      = 16;
  localparam int SHAPED_W     = 12;
  localparam int NEUTRAL_W    = 11;
  localparam int MAG_W        = NEUTRAL_W - 1;
  localparam int EXPO_W       = 11;
  localparam int EXPO_DEPTH   = 1 << MAG_W;
  localparam int CENTER_W     = 12;

  // Saturation limits
  localparam logic [TIME_W-1:0]  WIDTH_LIMIT    = 32'd65535;
  localparam logic [WIDTH_W-1:0] THROTTLE_LIMIT = 16'd2047;
  localparam int                 EXPO_MAX_K     = 2047;

  // Register reset values
  localparam logic [CENTER_W-1:0]         CENTER_RESET  = 12'd1500;
  localparam logic signed [NEUTRAL_W-1:0] DB_LOW_RESET  = -11'sd20;
  localparam logic signed [NEUTRAL_W-1:0] DB_HIGH_RESET = 11'sd20;

  typedef enum logic [1:0] {
    CH_THROTTLE = 2'd0,
    CH_AILERON  = 2'd1,
    CH_ELEVATOR = 2'd2,
    CH_RUDDER   = 2'd3
  } channel_t;

  typedef enum logic [1:0] {
    REG_CENTER  = 2'd0,
    REG_DB_LOW  = 2'd1,
    REG_DB_HIGH = 2'd2
  } reg_idx_t;

  // Live configuration
  typedef struct packed {
    logic [CENTER_W-1:0]         center_us;
    logic signed [NEUTRAL_W-1:0] deadband_low;
    logic signed [NEUTRAL_W-1:0] deadband_high;
  } cfg_t;

  // Measured pulse handed from edge capture to the shaper
  typedef struct packed {
    channel_t           ch;
    logic [WIDTH_W-1:0] width;
  } pulse_t;

  // Expo table entry: largest k with (374 k)^5 <= 1e5 * m^8,
  // i.e. floor(m^1.6 / 37.4), found by binary search over 0..2047.
  function automatic logic [EXPO_W-1:0] expo_entry(int m);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] base;
    int           lo;
    int           hi;
    int           mid;
    rhs = 128'd100000;
    for (int i = 0; i < 8; i++) begin
      rhs = rhs * 128'(m);
    end
    lo = 0;
    hi = EXPO_MAX_K;
    while (lo < hi) begin
      mid  = (lo + hi + 1) / 2;
      base = 128'(374 * mid);
      lhs  = base * base * base * base * base;
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return EXPO_W'(lo);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpd_cfg_regs.sv =====
`default_nettype none

module rpd_cfg_regs
  import rpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_us     <= CENTER_RESET;
      cfg.deadband_low  <= DB_LOW_RESET;
      cfg.deadband_high <= DB_HIGH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTER:  cfg.center_us     <= pwdata[CENTER_W-1:0];
        REG_DB_LOW:  cfg.deadband_low  <= pwdata[NEUTRAL_W-1:0];
        REG_DB_HIGH: cfg.deadband_high <= pwdata[NEUTRAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, deadband bounds sign-extended
  always_comb begin
    unique case (idx)
      REG_CENTER:  prdata = 32'(cfg.center_us);
      REG_DB_LOW:  prdata = 32'(cfg.deadband_low);
      REG_DB_HIGH: prdata = 32'(cfg.deadband_high);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpd_edge_capture.sv =====
`default_nettype none

module rpd_edge_capture
  import rpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_ch,
  input  wire logic              in_level,
  input  wire logic [TIME_W-1:0] in_time,
  output logic                   pulse_valid,
  input  wire logic              pulse_ready,
  output pulse_t                 pulse
);

  logic [TIME_W-1:0] rise_time [NUM_CHANNELS];
  logic              accept;
  logic              ch_ok;
  logic [TIME_W-1:0] diff;
  logic [WIDTH_W-1:0] width_sat;

  assign in_ready = !pulse_valid || pulse_ready;
  assign accept   = in_valid && in_ready;
  assign ch_ok    = 32'(in_ch) < NUM_CHANNELS;

  // Wrapping high time, saturated to 16 bits
  assign diff      = in_time - rise_time[in_ch];
  assign width_sat = (diff > WIDTH_LIMIT) ? WIDTH_LIMIT[WIDTH_W-1:0] : diff[WIDTH_W-1:0];

  // Rising edges store their timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_time[i] <= '0;
      end
    end else if (accept && in_level && ch_ok) begin
      rise_time[in_ch] <= in_time;
    end
  end

  // Falling edges load the measured pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (in_ready) begin
      pulse_valid <= accept && !in_level && ch_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pulse.ch    <= channel_t'(in_ch);
      pulse.width <= width_sat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpd_shaper.sv =====
`default_nettype none

module rpd_shaper
  import rpd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  cfg_t               cfg,
  input  wire logic          pulse_valid,
  output logic               pulse_ready,
  input  pulse_t             pulse,
  output logic               out_valid,
  input  wire logic          out_ready,
  output channel_t           out_ch,
  output logic [WIDTH_W-1:0] out_width,
  output logic [SHAPED_W-1:0] out_shaped
);

  // Constant expo table
  logic [EXPO_W-1:0]           expo_rom [EXPO_DEPTH];

  // Neutralize stage
  logic                        s2_valid;
  channel_t                    s2_ch;
  logic [WIDTH_W-1:0]          s2_width;
  logic [EXPO_W-1:0]           s2_thr;
  logic signed [NEUTRAL_W-1:0] s2_v;
  // Output stage
  logic                        s3_valid;
  channel_t                    s3_ch;
  logic [WIDTH_W-1:0]          s3_width;
  logic [EXPO_W-1:0]           s3_thr;
  logic signed [NEUTRAL_W-1:0] s3_v;
  logic                        s3_neg;
  logic                        s3_in_band;
  logic [EXPO_W-1:0]           s3_expo;

  logic                        en2;
  logic                        en3;
  logic signed [17:0]          off;
  logic signed [NEUTRAL_W-1:0] v_sat;
  logic [EXPO_W-1:0]           thr_sat;
  logic [MAG_W-1:0]            mag;
  logic                        in_band;

  for (genvar g = 0; g < EXPO_DEPTH; g++) begin : g_expo_rom
    assign expo_rom[g] = expo_entry(g);
  end

  assign en3         = !s3_valid || out_ready;
  assign en2         = !s2_valid || en3;
  assign pulse_ready = en2;

  // Center minus width, clamped to +/-1023; throttle clamp to 2047
  assign off = $signed({6'd0, cfg.center_us}) - $signed({2'd0, pulse.width});
  always_comb begin
    if (off > 18'sd1023) begin
      v_sat = 11'sd1023;
    end else if (off < -18'sd1023) begin
      v_sat = -11'sd1023;
    end else begin
      v_sat = off[NEUTRAL_W-1:0];
    end
  end
  assign thr_sat = (pulse.width > THROTTLE_LIMIT) ? THROTTLE_LIMIT[EXPO_W-1:0]
                                                  : pulse.width[EXPO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= pulse_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ch    <= pulse.ch;
      s2_width <= pulse.width;
      s2_thr   <= thr_sat;
      s2_v     <= v_sat;
    end
  end

  // Magnitude for the expo lookup, deadband test for the rudder
  assign mag     = s2_v[NEUTRAL_W-1] ? MAG_W'(-s2_v) : s2_v[MAG_W-1:0];
  assign in_band = (s2_v >= cfg.deadband_low) && (s2_v <= cfg.deadband_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ch      <= s2_ch;
      s3_width   <= s2_width;
      s3_thr     <= s2_thr;
      s3_v       <= s2_v;
      s3_neg     <= s2_v[NEUTRAL_W-1];
      s3_in_band <= in_band;
      s3_expo    <= expo_rom[mag];
    end
  end

  // Per-channel result select
  always_comb begin
    unique case (s3_ch)
      CH_THROTTLE: out_shaped = {1'b0, s3_thr};
      CH_RUDDER:   out_shaped = s3_in_band ? '0 : {s3_v[NEUTRAL_W-1], s3_v};
      CH_AILERON, CH_ELEVATOR: begin
        out_shaped = s3_neg ? SHAPED_W'(-{1'b0, s3_expo}) : {1'b0, s3_expo};
      end
      default:     out_shaped = '0;
    endcase
  end

  assign out_valid = s3_valid;
  assign out_ch    = s3_ch;
  assign out_width = s3_width;

endmodule

`default_nettype wire

// ===== rtl/core/rc_pwm_channel_decoder_core.sv =====
// RC PWM channel decoder, four channels.
// Input stream: one transfer per pin edge. s_tdata carries the 32-bit
// microsecond timestamp, s_tuser the channel and the new pin level.
// Rising edges only store the timestamp; each falling edge yields one
// output transfer with the channel, the 16-bit saturated pulse width and
// the shaped value (throttle raw, aileron/elevator expo, rudder deadband).
// A falling edge passes the edge capture, neutralize and output registers,
// in that order, before it shows on m_tvalid.
// Throughput: one edge per cycle while m_tready is high; the stages are edge
// capture, neutralize, and the registered expo ROM read.
// A stalled m_tready holds the output; s_tready stays high while any stage
// behind the output is empty, so up to two more falling edges are taken.
// Reset clears all stored rise times to 0 and loads center 1500 and
// deadband -20..20. Configuration is APB: center at 0x0, deadband low
// at 0x4, deadband high at 0x8; write only while no edge is in flight.
`default_nettype none

module rc_pwm_channel_decoder_core
  import rpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Edge events
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] time_us
  input  wire logic [2:0]  s_tuser,   // [1:0] channel, [2] level
  // Decoded pulses
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [15:0] pulse_width, [27:16] shaped_value, [31:28] zero
  output logic [1:0]       m_tuser,   // [1:0] out_channel
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t                cfg;
  pulse_t              pulse;
  logic                pulse_valid;
  logic                pulse_ready;
  channel_t            out_ch;
  logic [WIDTH_W-1:0]  out_width;
  logic [SHAPED_W-1:0] out_shaped;

  rpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpd_edge_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_ch       (s_tuser[1:0]),
    .in_level    (s_tuser[2]),
    .in_time     (s_tdata),
    .pulse_valid (pulse_valid),
    .pulse_ready (pulse_ready),
    .pulse       (pulse)
  );

  rpd_shaper u_shaper (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pulse_valid (pulse_valid),
    .pulse_ready (pulse_ready),
    .pulse       (pulse),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_ch      (out_ch),
    .out_width   (out_width),
    .out_shaped  (out_shaped)
  );

  assign m_tuser = out_ch;
  assign m_tdata = {4'd0, out_shaped, out_width};

  // An empty output stage means the whole pipe can advance
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage is empty");

  // Throttle result is the width clamped to 2047
  a_throttle_clamp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_ch == CH_THROTTLE)) |->
      (out_shaped == ((out_width > THROTTLE_LIMIT) ? 12'd2047 : out_width[SHAPED_W-1:0])))
    else $error("throttle value does not match clamped width");

  // Rudder result stays within the neutral range
  a_rudder_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_ch == CH_RUDDER)) |->
      (out_shaped[SHAPED_W-1] == out_shaped[SHAPED_W-2]))
    else $error("rudder value outside +/-1023");

endmodule

`default_nettype wire

// ===== bench/rc_pwm_channel_decoder_core_tb.sv =====
`timescale 1ns / 100ps

module rc_pwm_channel_decoder_core_tb;
  import rpd_pkg::*;

  // Register stages between an edge transfer and its output transfer
  localparam int PIPE_DEPTH   = 3;
  localparam int ADDR_STRIDE  = 4;
  // Register slot past the last real one; writes there must be dropped
  localparam int REG_UNUSED   = 3;
  localparam int WIDTH_MAX    = 65535;
  localparam int THROTTLE_MAX = 2047;
  localparam int NEUTRAL_MAX  = 1023;
  localparam int EXPO_K_MAX   = 2047;
  // |v|^1.6 / 37.4 checked as (374 k)^5 <= 1e5 * |v|^8
  localparam int EXPO_DIV_X10 = 374;
  localparam int EXPO_SCALE   = 100000;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_t;

  typedef struct {
    channel_t    ch;
    logic [15:0] width;
    logic [11:0] shaped;
  } pulse_rec_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] time_us
  logic [2:0]  s_tuser;   // [1:0] channel, [2] level
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [15:0] pulse_width, [27:16] shaped_value, [31:28] zero
  logic [1:0]  m_tuser;   // [1:0] out_channel
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [31:0]          rise_stamp [NUM_CHANNELS];
  logic [CENTER_W-1:0]  center_cfg;
  int                   db_lo_cfg;
  int                   db_hi_cfg;
  pulse_rec_t           pending_pulses [$];

  int          mismatches;
  logic [31:0] now_us;
  bit          tx_idle;
  int          burst_left;
  rx_mode_t    rx_mode;
  int          hold_req;
  int          hold_left;
  int unsigned rx_tick;

  rc_pwm_channel_decoder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Largest k with k <= |v|^1.6 / 37.4, by binary search in wide integers
  function automatic int expo_curve(int mag);
    logic [127:0] lim;
    logic [127:0] lhs;
    logic [127:0] step;
    int lo, hi, mid, i;
    lim = 128'(EXPO_SCALE);
    for (i = 0; i < 8; i++) lim = lim * 128'(mag);
    lo = 0;
    hi = EXPO_K_MAX;
    while (lo < hi) begin
      mid  = (lo + hi + 1) / 2;
      step = 128'(EXPO_DIV_X10 * mid);
      lhs  = step * step * step * step * step;
      if (lhs <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Expected output for a falling edge at the given timestamp
  function automatic pulse_rec_t decode_pulse(channel_t ch, logic [31:0] stamp);
    pulse_rec_t  rec;
    logic [31:0] span;
    int w, v, s, e;
    span = stamp - rise_stamp[ch];
    w = (span > 32'(WIDTH_MAX)) ? WIDTH_MAX : int'(span);
    if (ch == CH_THROTTLE) begin
      s = (w > THROTTLE_MAX) ? THROTTLE_MAX : w;
    end else begin
      v = int'(center_cfg) - w;
      if (v > NEUTRAL_MAX) v = NEUTRAL_MAX;
      if (v < -NEUTRAL_MAX) v = -NEUTRAL_MAX;
      if (ch == CH_RUDDER) begin
        s = (v >= db_lo_cfg && v <= db_hi_cfg) ? 0 : v;
      end else begin
        e = expo_curve(v < 0 ? -v : v);
        s = (v < 0) ? -e : e;
      end
    end
    rec.ch     = ch;
    rec.width  = 16'(w);
    rec.shaped = 12'(s);
    return rec;
  endfunction

  // Pulse widths aimed at the interesting corners of the current settings
  function automatic int pick_width();
    int w;
    case ($urandom_range(0, 7))
      0: w = int'($urandom_range(0, 64));
      1: w = int'($urandom_range(65500, 65600));
      2: w = int'(center_cfg) - db_hi_cfg + int'($urandom_range(0, 2)) - 1;
      3: w = int'(center_cfg) - db_lo_cfg + int'($urandom_range(0, 2)) - 1;
      4: w = int'($urandom_range(1990, 2100));
      default: w = int'(center_cfg) + int'($urandom_range(0, 2300)) - 1150;
    endcase
    return (w < 0) ? 0 : w;
  endfunction

  // One edge transfer; the sender idles between bursts when tx_idle is set
  task automatic send_edge(channel_t ch, bit lvl, logic [31:0] stamp);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = tx_idle ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    s_tuser  <= {lvl, ch};
    do @(posedge clk); while (!s_tready);
    if (lvl) rise_stamp[ch] = stamp;
    else pending_pulses.push_back(decode_pulse(ch, stamp));
  endtask

  task automatic send_pulse(channel_t ch, int unsigned width);
    send_edge(ch, 1'b1, now_us);
    send_edge(ch, 1'b0, now_us + width);
    now_us = now_us + width;
  endtask

  // Stop sending and let every expected result come out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic apb_write(int idx, int value);
    logic [31:0] data;
    data = value;
    // bits above the field are don't-care
    if ($urandom_range(0, 1)) data[31:12] = 20'($urandom);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * ADDR_STRIDE);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CENTER:  center_cfg = data[CENTER_W-1:0];
      REG_DB_LOW:  db_lo_cfg  = int'($signed(data[NEUTRAL_W-1:0]));
      REG_DB_HIGH: db_hi_cfg  = int'($signed(data[NEUTRAL_W-1:0]));
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int center, int db_lo, int db_hi);
    drain();
    apb_write(REG_CENTER, center);
    apb_write(REG_DB_LOW, db_lo);
    apb_write(REG_DB_HIGH, db_hi);
  endtask

  // Falling edges with no rise since reset measure from time zero
  task automatic test_reset_state();
    send_edge(CH_AILERON, 1'b0, 32'd1500);
    send_edge(CH_THROTTLE, 1'b0, 32'd3000);
    send_edge(CH_RUDDER, 1'b0, 32'd1520);
    send_edge(CH_ELEVATOR, 1'b0, 32'd0);
  endtask

  task automatic test_width_limits();
    now_us = 32'hFFFF_FF00;
    send_pulse(CH_THROTTLE, 0);
    // crosses the timestamp wrap
    send_pulse(CH_THROTTLE, 2048);
    send_pulse(CH_THROTTLE, 65536);
    send_pulse(CH_AILERON, 477);
    send_pulse(CH_ELEVATOR, 2523);
    // second rise replaces the first
    send_edge(CH_AILERON, 1'b1, now_us);
    send_edge(CH_AILERON, 1'b1, now_us + 100);
    send_edge(CH_AILERON, 1'b0, now_us + 600);
    now_us = now_us + 1000;
  endtask

  // Rudder values just inside and just outside the default deadband
  task automatic test_rudder_deadband();
    send_pulse(CH_RUDDER, 1521);
    send_pulse(CH_RUDDER, 1520);
    send_pulse(CH_RUDDER, 1480);
    send_pulse(CH_RUDDER, 1479);
  endtask

  // Mostly well-formed pulses, the rest stray or broken edges
  task automatic test_random_edges(int steps);
    channel_t ch;
    repeat (steps) begin
      ch = channel_t'($urandom_range(0, NUM_CHANNELS - 1));
      case ($urandom_range(0, 9))
        0: send_edge(ch, 1'b1, now_us + $urandom_range(0, 5000));
        1: send_edge(ch, 1'b0, now_us + $urandom_range(0, 5000));
        2: send_edge(ch, 1'b0, $urandom);
        3: begin
          send_edge(ch, 1'b1, now_us);
          now_us = now_us + $urandom_range(1, 3000);
          send_pulse(ch, pick_width());
        end
        default: send_pulse(ch, pick_width());
      endcase
      if ($urandom_range(0, 15) == 0) now_us = $urandom;
      else now_us = now_us + $urandom_range(1, 20000);
    end
  endtask

  task automatic test_config_extremes();
    rx_mode = RX_PERIODIC;
    set_config(0, -NEUTRAL_MAX, NEUTRAL_MAX);
    test_random_edges(50);
    // empty deadband: nothing is zeroed
    rx_mode = RX_SLOW;
    set_config(4095, NEUTRAL_MAX, -NEUTRAL_MAX);
    test_random_edges(50);
  endtask

  task automatic test_unused_register();
    drain();
    apb_write(REG_UNUSED, $urandom);
    repeat (8) send_pulse($urandom_range(0, 1) ? CH_RUDDER : CH_AILERON, pick_width());
  endtask

  task automatic test_random_config();
    int center;
    rx_mode = RX_RANDOM;
    repeat (2) begin
      center = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(1300, 1700);
      set_config(center, int'($urandom_range(0, 2046)) - NEUTRAL_MAX,
                 int'($urandom_range(0, 2046)) - NEUTRAL_MAX);
      test_random_edges(50);
    end
  endtask

  // Receiver holds off while the sender keeps offering back-to-back edges
  task automatic test_backpressure();
    set_config(CENTER_RESET, DB_LOW_RESET, DB_HIGH_RESET);
    tx_idle  = 1'b0;
    rx_mode  = RX_FREE;
    hold_req = 120;
    repeat (20) send_pulse(channel_t'($urandom_range(0, NUM_CHANNELS - 1)), pick_width());
    drain();
    // no idling on either side
    test_random_edges(40);
    tx_idle = 1'b1;
  endtask

  // Receiver stall pattern, with a long hold on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:     m_tready <= 1'b1;
        RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: m_tready <= ((rx_tick % 7) < 4);
        default:     m_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Compare each output transfer with the oldest expected pulse
  always @(posedge clk) begin : check_pulses
    pulse_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pulses.size() == 0) begin
        $display("%0t: unexpected output ch=%0d width=%0d shaped=%0d", $time, m_tuser,
                 m_tdata[15:0], $signed(m_tdata[27:16]));
        mismatches++;
      end else begin
        want = pending_pulses.pop_front();
        if (m_tuser != want.ch) begin
          $display("%0t: channel expected %0d actual %0d", $time, want.ch, m_tuser);
          mismatches++;
        end
        if (m_tdata[15:0] != want.width) begin
          $display("%0t: pulse_width expected %0d actual %0d", $time, want.width,
                   m_tdata[15:0]);
          mismatches++;
        end
        if (m_tdata[27:16] != want.shaped) begin
          $display("%0t: shaped_value expected %0d actual %0d", $time,
                   $signed(want.shaped), $signed(m_tdata[27:16]));
          mismatches++;
        end
        if (m_tdata[31:28] != 4'd0) begin
          $display("%0t: pad bits expected 0 actual %0h", $time, m_tdata[31:28]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    m_tready   = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    burst_left = 0;
    hold_req   = 0;
    hold_left  = 0;
    rx_tick    = 0;
    tx_idle    = 1'b1;
    rx_mode    = RX_RANDOM;
    now_us     = $urandom;
    center_cfg = CENTER_RESET;
    db_lo_cfg  = int'(DB_LOW_RESET);
    db_hi_cfg  = int'(DB_HIGH_RESET);
    for (int i = 0; i < NUM_CHANNELS; i++) rise_stamp[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_width_limits();
    test_rudder_deadband();
    test_random_edges(70);
    test_config_extremes();
    test_unused_register();
    test_random_config();
    test_backpressure();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_pulses.size() == 0) begin
      $display("rc_pwm_channel_decoder_core test passed");
    end else begin
      $display("rc_pwm_channel_decoder_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("rc_pwm_channel_decoder_core test failed");
    $finish;
  end

endmodule
